// ===== hdl/dptm_pkg.sv =====
// ----------------------------------------------------------------------------
// dptm_pkg
// Shared types and constants for the decimal prefix trie matcher.
// ----------------------------------------------------------------------------
package dptm_pkg;

  localparam int unsigned NODE_COUNT_DEF = 256;
  localparam int unsigned MAX_DIGITS_DEF = 16;

  localparam int unsigned FANOUT  = 10;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned KIND_W  = 2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INNER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERM  = 2'd2;

  localparam logic [1:0] STATUS_ADD_DONE = 2'd0;
  localparam logic [1:0] STATUS_ADD_FULL = 2'd1;
  localparam logic [1:0] STATUS_MATCH    = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic [TAG_W-1:0]   tag_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] first_len;
    logic [LEN_W-1:0] long_len;
    logic [TAG_W-1:0] tag_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_ALLOC
  } state_e;

endpackage

// ===== hdl/dptm_ram.sv =====
// ----------------------------------------------------------------------------
// dptm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dptm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/decimal_prefix_trie_match.sv =====
// ----------------------------------------------------------------------------
// decimal_prefix_trie_match
// Ten-way decimal trie in a node memory: add prefixes with tags, match
// digit strings against the stored prefixes.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------
//   input   | in  | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//   output  | out | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// Each digit does an entry read in ST_IDLE, then its update in ST_UPDATE.
// An add digit that creates a node then clears its ten entries in ST_ALLOC.
// After reset the root node's entries are cleared in ST_CLEAR; in_stall_o is high.
// A last digit waits in the update cycle while the output register is
// stalled and full; only a last digit produces a transfer on the output.
// ----------------------------------------------------------------------------
module decimal_prefix_trie_match
  import dptm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW    = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned NFW   = $clog2(NODE_COUNT + 1);
  localparam int unsigned DEPTH = NODE_COUNT * FANOUT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned EW    = KIND_W + TAG_W + CW;
  localparam int unsigned SW    = $clog2(FANOUT);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [CW-1:0]     child;
  } entry_t;

  function automatic logic [AW-1:0] entry_addr(logic [CW-1:0] node,
                                               logic [DIGIT_W-1:0] dig);
    logic [AW-1:0] n;
    n = AW'(node);
    return (n << 3) + (n << 1) + AW'(dig);
  endfunction

  state_e         state_q, state_d;
  in_item_t       item_q, item_d;
  logic [CW-1:0]  cursor_q, cursor_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [PW-1:0]  first_q, first_d;
  logic [PW-1:0]  longer_q, longer_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic           stopped_q, stopped_d;
  logic           failed_q, failed_d;
  logic [NFW-1:0] next_free_q, next_free_d;
  logic [AW-1:0]  sweep_addr_q, sweep_addr_d;
  logic [SW-1:0]  sweep_cnt_q, sweep_cnt_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_rdata;
  entry_t         wr_entry, rd_entry;
  logic           bad_digit;
  logic [PW-1:0]  pos_inc;

  assign rd_entry = entry_t'(ram_rdata);
  assign pos_inc  = pos_q + PW'(1);
  assign bad_digit = (item_q.digit > DIGIT_W'(FANOUT - 1)) ||
                     (pos_q >= PW'(MAX_DIGITS));

  dptm_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cursor_d     = cursor_q;
    pos_d        = pos_q;
    first_d      = first_q;
    longer_d     = longer_q;
    tag_d        = tag_q;
    stopped_d    = stopped_q;
    failed_d     = failed_q;
    next_free_d  = next_free_q;
    sweep_addr_d = sweep_addr_q;
    sweep_cnt_d  = sweep_cnt_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    in_stall_o   = 1'b1;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = entry_addr(cursor_q, item_q.digit);
    ram_raddr    = entry_addr(cursor_q, in_item_i.digit);
    wr_entry     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR, ST_ALLOC: begin
        ram_we       = 1'b1;
        ram_waddr    = sweep_addr_q;
        sweep_addr_d = sweep_addr_q + AW'(1);
        sweep_cnt_d  = sweep_cnt_q + SW'(1);
        if (sweep_cnt_q == SW'(FANOUT - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d  = in_item_i;
          ram_re  = (in_item_i.digit <= DIGIT_W'(FANOUT - 1));
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        if (!(item_q.last && out_valid_q && out_stall_i)) begin
          state_d = ST_IDLE;
          if (item_q.opcode == OP_ADD) begin
            if (!failed_q) begin
              if (bad_digit) begin
                failed_d = 1'b1;
              end else if (item_q.last) begin
                ram_we   = 1'b1;
                wr_entry = '{kind: KIND_TERM, tag: item_q.tag_in, child: rd_entry.child};
              end else begin
                wr_entry = rd_entry;
                if (rd_entry.kind == KIND_EMPTY) begin
                  wr_entry.kind = KIND_INNER;
                end
                if (rd_entry.child != '0) begin
                  ram_we   = 1'b1;
                  cursor_d = rd_entry.child;
                  pos_d    = pos_inc;
                end else if (next_free_q >= NFW'(NODE_COUNT)) begin
                  failed_d = 1'b1;
                end else begin
                  ram_we         = 1'b1;
                  wr_entry.child = next_free_q[CW-1:0];
                  cursor_d       = next_free_q[CW-1:0];
                  pos_d          = pos_inc;
                  next_free_d    = next_free_q + NFW'(1);
                  sweep_addr_d   = entry_addr(next_free_q[CW-1:0], '0);
                  sweep_cnt_d    = '0;
                  state_d        = ST_ALLOC;
                end
              end
            end
          end else if (!stopped_q) begin
            if (bad_digit || rd_entry.kind == KIND_EMPTY) begin
              stopped_d = 1'b1;
            end else begin
              cursor_d = rd_entry.child;
              pos_d    = pos_inc;
              if (rd_entry.kind == KIND_TERM) begin
                if (first_q == '0) begin
                  first_d = pos_inc;
                end else begin
                  longer_d = pos_inc;
                end
                tag_d = rd_entry.tag;
                if (rd_entry.child == '0) begin
                  stopped_d = 1'b1;
                  cursor_d  = cursor_q;
                  pos_d     = pos_q;
                end
              end
            end
          end

          if (item_q.last) begin
            out_valid_d = 1'b1;
            if (item_q.opcode == OP_ADD) begin
              out_d = '{status: failed_d ? STATUS_ADD_FULL : STATUS_ADD_DONE,
                        first_len: '0, long_len: '0, tag_out: '0};
            end else begin
              out_d = '{status: STATUS_MATCH, first_len: LEN_W'(first_d),
                        long_len: LEN_W'(longer_d), tag_out: tag_d};
            end
            cursor_d  = '0;
            pos_d     = '0;
            first_d   = '0;
            longer_d  = '0;
            tag_d     = '0;
            stopped_d = 1'b0;
            failed_d  = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cursor_q     <= '0;
      pos_q        <= '0;
      first_q      <= '0;
      longer_q     <= '0;
      tag_q        <= '0;
      stopped_q    <= 1'b0;
      failed_q     <= 1'b0;
      next_free_q  <= NFW'(1);
      sweep_addr_q <= '0;
      sweep_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      pos_q        <= pos_d;
      first_q      <= first_d;
      longer_q     <= longer_d;
      tag_q        <= tag_d;
      stopped_q    <= stopped_d;
      failed_q     <= failed_d;
      next_free_q  <= next_free_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_cnt_q  <= sweep_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== verif/decimal_prefix_trie_match_tb.sv =====
// ----------------------------------------------------------------------------
// decimal_prefix_trie_match_tb
// Self-checking bench for the decimal prefix trie matcher. A short table of
// digit strings covers the corner cases, then random add, match, broken and
// mixed strings follow. Every answer is checked against either the expected
// value in the table or a behavioural trie kept inside the bench, with random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module decimal_prefix_trie_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dptm_pkg::*;

  localparam int NODES        = NODE_COUNT_DEF;
  localparam int DEPTH        = MAX_DIGITS_DEF;
  localparam int SEQ_MAX      = 20;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_PCT     = 36;

  typedef struct packed {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } vector_row_t;

  localparam out_item_t NO_WANT = '0;
  localparam int DIRECTED_ROWS = 19;
  localparam vector_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{OP_MATCH, 4'd0, 1'b1, 32'h0000_0000}, 1'b1, '{STATUS_MATCH, 5'd0, 5'd0, 32'h0}},
    '{'{OP_ADD, 4'd9, 1'b1, 32'hFFFF_FFFF}, 1'b1, '{STATUS_ADD_DONE, 5'd0, 5'd0, 32'h0}},
    '{'{OP_MATCH, 4'd9, 1'b1, 32'h0000_0000}, 1'b1,
      '{STATUS_MATCH, 5'd1, 5'd0, 32'hFFFF_FFFF}},
    '{'{OP_ADD, 4'd1, 1'b1, 32'h1111_1111}, 1'b1, '{STATUS_ADD_DONE, 5'd0, 5'd0, 32'h0}},
    '{'{OP_ADD, 4'd1, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_ADD, 4'd2, 1'b0, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
    '{'{OP_ADD, 4'd3, 1'b1, 32'h0000_0123}, 1'b1, '{STATUS_ADD_DONE, 5'd0, 5'd0, 32'h0}},
    '{'{OP_MATCH, 4'd1, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_MATCH, 4'd2, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_MATCH, 4'd3, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_MATCH, 4'd4, 1'b1, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_ADD, 4'd10, 1'b1, 32'h5555_AAAA}, 1'b1, '{STATUS_ADD_FULL, 5'd0, 5'd0, 32'h0}},
    '{'{OP_MATCH, 4'd15, 1'b1, 32'h0000_0000}, 1'b1, '{STATUS_MATCH, 5'd0, 5'd0, 32'h0}},
    '{'{OP_ADD, 4'd1, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_ADD, 4'd2, 1'b1, 32'h0000_0012}, 1'b0, NO_WANT},
    '{'{OP_MATCH, 4'd1, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_MATCH, 4'd2, 1'b1, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{OP_ADD, 4'd7, 1'b0, 32'hDEAD_0007}, 1'b0, NO_WANT},
    '{'{OP_MATCH, 4'd9, 1'b1, 32'h0000_0000}, 1'b0, NO_WANT}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bit [KIND_W-1:0] trie_kind  [NODES*FANOUT];
  bit [TAG_W-1:0]  trie_tag   [NODES*FANOUT];
  int unsigned     trie_child [NODES*FANOUT];
  int unsigned     pool_next  = 1;
  int unsigned     walk_node  = 0;
  int unsigned     walk_pos   = 0;
  int unsigned     hit_first  = 0;
  int unsigned     hit_longer = 0;
  bit [TAG_W-1:0]  hit_tag    = '0;
  bit              walk_halted = 1'b0;
  bit              add_broken  = 1'b0;

  out_item_t   answer_q [$];
  logic [63:0] book_digits [$];
  int unsigned book_len [$];

  int fail_count  = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int in_gap_pct  = IDLE_PCT;

  always #5ns clk = ~clk;

  decimal_prefix_trie_match u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  function automatic bit predict_trie_step(input in_item_t it, output out_item_t res);
    int unsigned slot;
    int unsigned k;
    res = '0;
    if (it.opcode == OP_ADD) begin
      if (!add_broken) begin
        if (it.digit >= FANOUT || walk_pos >= DEPTH || walk_node >= NODES) begin
          add_broken = 1'b1;
        end else begin
          slot = walk_node * FANOUT + it.digit;
          if (it.last) begin
            trie_kind[slot] = KIND_TERM;
            trie_tag[slot]  = it.tag_in;
          end else if (trie_child[slot] != 0) begin
            if (trie_kind[slot] == KIND_EMPTY) trie_kind[slot] = KIND_INNER;
            walk_node = trie_child[slot];
            walk_pos++;
          end else if (pool_next >= NODES) begin
            add_broken = 1'b1;
          end else begin
            if (trie_kind[slot] == KIND_EMPTY) trie_kind[slot] = KIND_INNER;
            for (k = 0; k < FANOUT; k++) begin
              trie_kind[pool_next*FANOUT+k]  = KIND_EMPTY;
              trie_tag[pool_next*FANOUT+k]   = '0;
              trie_child[pool_next*FANOUT+k] = 0;
            end
            trie_child[slot] = pool_next;
            walk_node = pool_next;
            pool_next++;
            walk_pos++;
          end
        end
      end
    end else if (!walk_halted) begin
      if (it.digit >= FANOUT || walk_pos >= DEPTH || walk_node >= NODES) begin
        walk_halted = 1'b1;
      end else begin
        slot = walk_node * FANOUT + it.digit;
        if (trie_kind[slot] == KIND_EMPTY) begin
          walk_halted = 1'b1;
        end else begin
          if (trie_kind[slot] == KIND_TERM) begin
            if (hit_first == 0) hit_first = walk_pos + 1;
            else hit_longer = walk_pos + 1;
            hit_tag = trie_tag[slot];
            if (trie_child[slot] == 0) walk_halted = 1'b1;
          end
          if (!walk_halted) begin
            walk_node = trie_child[slot];
            walk_pos++;
          end
        end
      end
    end
    if (!it.last) return 1'b0;
    if (it.opcode == OP_ADD) begin
      res.status = add_broken ? STATUS_ADD_FULL : STATUS_ADD_DONE;
    end else begin
      res.status    = STATUS_MATCH;
      res.first_len = LEN_W'(hit_first);
      res.long_len  = LEN_W'(hit_longer);
      res.tag_out   = hit_tag;
    end
    walk_node   = 0;
    walk_pos    = 0;
    hit_first   = 0;
    hit_longer  = 0;
    hit_tag     = '0;
    walk_halted = 1'b0;
    add_broken  = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_trie_step(it, res)) answer_q.push_back(typed ? want : res);
  endtask

  task automatic run_random_string();
    logic [3:0]  dig [SEQ_MAX];
    logic [63:0] pfx;
    logic        whole_op;
    bit          mixed;
    bit          keep;
    int          len;
    int          pick;
    int          i;
    int unsigned roll;
    in_item_t    it;
    roll     = $urandom_range(0, 99);
    len      = $urandom_range(1, 6);
    whole_op = OP_ADD;
    mixed    = 1'b0;
    keep     = 1'b0;
    for (i = 0; i < SEQ_MAX; i++) dig[i] = 4'($urandom_range(0, 9));
    if (roll < 30) begin
      keep = 1'b1;
    end else if (roll < 40) begin
      len  = $urandom_range(12, DEPTH);
      keep = 1'b1;
    end else if (roll < 80 && book_len.size() != 0) begin
      pick     = $urandom_range(0, book_len.size() - 1);
      len      = $urandom_range(1, book_len[pick] + 4);
      whole_op = OP_MATCH;
      if (len > SEQ_MAX) len = SEQ_MAX;
      for (i = 0; i < book_len[pick]; i++) dig[i] = book_digits[pick][4*i +: 4];
    end else if (roll < 88) begin
      len      = $urandom_range(1, 8);
      whole_op = OP_MATCH;
    end else if (roll < 94) begin
      whole_op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) len = $urandom_range(DEPTH + 1, SEQ_MAX);
      else dig[$urandom_range(0, len - 1)] = 4'($urandom_range(10, 15));
    end else begin
      mixed = 1'b1;
      for (i = 0; i < SEQ_MAX; i++) dig[i] = 4'($urandom_range(0, 15));
    end
    if (keep) begin
      pfx = '0;
      for (i = 0; i < len; i++) pfx[4*i +: 4] = dig[i];
      book_digits.push_back(pfx);
      book_len.push_back(len);
    end
    for (i = 0; i < len; i++) begin
      it.opcode = mixed ? 1'($urandom_range(0, 1)) : whole_op;
      it.digit  = dig[i];
      it.last   = (i == len - 1);
      it.tag_in = $urandom();
      send_item(it, 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    out_stall   <= (cycle_count < 3000 || cycle_count > 6000) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, out_item);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (out_item.status !== want.status || out_item.first_len !== want.first_len ||
            out_item.long_len !== want.long_len || out_item.tag_out !== want.tag_out) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_item);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[r]) send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      in_gap_pct = (items_sent > 300 && items_sent < 450) ? 0 : IDLE_PCT;
      run_random_string();
    end
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
